// ===== src/assert_macros.svh =====
// Assertion helpers shared by the pattern checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PMTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pmtc_pkg.sv =====
package pmtc_pkg;

    localparam int WORD_BITS       = 32;
    localparam int LFSR_BITS       = 15;
    localparam int WORD_INDEX_BITS = 30;
    localparam int KIND_BITS       = 2;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;
    localparam int COUNT_BITS      = 31;
    localparam int LFSR_PERIOD     = 32767;

    typedef logic [LFSR_BITS-1:0] t_lfsr;

    localparam t_lfsr LFSR_SEED   = 15'h0001;
    localparam t_lfsr LFSR_TOGGLE = 15'h6000;

    // Item kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_RESTART = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SEED  = 2'd0,
        CFG_BASE  = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE,
        ST_SKIP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic restart;
        logic skip_step;
        logic word_op;
        logic is_check;
        logic res_restart;
        logic res_zero;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip_done;
    } t_dp_status;

    // One LFSR step: shift right, toggle taps when a one falls out
    function automatic t_lfsr lfsr_step(input t_lfsr s);
        return (s >> 1) ^ (s[0] ? LFSR_TOGGLE : t_lfsr'(0));
    endfunction

    typedef logic [LFSR_BITS-1:0][WORD_BITS-1:0] t_word_cols;
    typedef logic [LFSR_BITS-1:0][LFSR_BITS-1:0] t_state_cols;

    // Word bits contributed by each state bit (the generator is linear)
    function automatic t_word_cols build_word_cols();
        t_word_cols cols;
        t_lfsr      s;
        for (int j = 0; j < LFSR_BITS; j++) begin
            s = t_lfsr'(1) << j;
            for (int b = 0; b < WORD_BITS; b++) begin
                cols[j][b] = s[0];
                s = lfsr_step(s);
            end
        end
        return cols;
    endfunction

    // State after one full word contributed by each state bit
    function automatic t_state_cols build_state_cols();
        t_state_cols cols;
        t_lfsr       s;
        for (int j = 0; j < LFSR_BITS; j++) begin
            s = t_lfsr'(1) << j;
            for (int b = 0; b < WORD_BITS; b++) begin
                s = lfsr_step(s);
            end
            cols[j] = s;
        end
        return cols;
    endfunction

    localparam t_word_cols  WORD_COLS  = build_word_cols();
    localparam t_state_cols STATE_COLS = build_state_cols();

    function automatic logic [WORD_BITS-1:0] pattern_word(input t_lfsr s);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int j = 0; j < LFSR_BITS; j++) begin
            if (s[j]) w = w ^ WORD_COLS[j];
        end
        return w;
    endfunction

    function automatic t_lfsr pattern_advance(input t_lfsr s);
        t_lfsr n;
        n = '0;
        for (int j = 0; j < LFSR_BITS; j++) begin
            if (s[j]) n = n ^ STATE_COLS[j];
        end
        return n;
    endfunction

    // Reduce a 32-bit value modulo 2^15-1 by folding 15-bit chunks
    function automatic t_lfsr seed_reduce(input logic [CFG_DATA_BITS-1:0] d);
        logic [16:0] s;
        logic [15:0] f;
        s = 17'(d[14:0]) + 17'(d[29:15]) + 17'(d[31:30]);
        f = 16'(s[14:0]) + 16'(s[16:15]);
        if (f >= 16'(LFSR_PERIOD)) f = f - 16'(LFSR_PERIOD);
        return f[LFSR_BITS-1:0];
    endfunction

endpackage

// ===== src/pmtc_in_if.sv =====
interface pmtc_in_if import pmtc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [WORD_BITS-1:0] read_data;

    modport source (output valid, kind, read_data, input ready);
    modport sink   (input valid, kind, read_data, output ready);
endinterface

// ===== src/pmtc_out_if.sv =====
interface pmtc_out_if import pmtc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] data_word;
    logic                 mismatch;
    logic [WORD_BITS-1:0] word_address;
    logic [WORD_BITS-1:0] error_count;
    logic                 last_word;

    modport source (output valid, data_word, mismatch, word_address, error_count, last_word,
                    input ready);
    modport sink   (input valid, data_word, mismatch, word_address, error_count, last_word,
                    output ready);
endinterface

// ===== src/prbs_memory_test_checker_unit.sv =====
// Write and check items: one item per cycle, result valid the cycle after acceptance.
// Restart items: the skip counter takes the seed mod 32767 and advances the generator by
// one full 32-bit word each cycle while no item is taken, then the result is posted.
// A stalled output holds its result; the next item is taken in the cycle the result leaves.
// Synchronous active-low reset: generator 1, index and error count 0, config to defaults.
module prbs_memory_test_checker_unit import pmtc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    pmtc_in_if.sink                   i_item,
    pmtc_out_if.source                o_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;

    pmtc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_kind      (t_kind'(i_item.kind)),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pmtc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .i_read_data    (i_item.read_data),
        .o_status       (w_status),
        .o_data_word    (o_result.data_word),
        .o_mismatch     (o_result.mismatch),
        .o_word_address (o_result.word_address),
        .o_error_count  (o_result.error_count),
        .o_last_word    (o_result.last_word)
    );

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;

endmodule

// ===== src/pmtc_datapath.sv =====
`include "assert_macros.svh"

module pmtc_datapath import pmtc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  t_dp_cmd                   i_cmd,
    input  logic [WORD_BITS-1:0]      i_read_data,
    output t_dp_status                o_status,
    output logic [WORD_BITS-1:0]      o_data_word,
    output logic                      o_mismatch,
    output logic [WORD_BITS-1:0]      o_word_address,
    output logic [WORD_BITS-1:0]      o_error_count,
    output logic                      o_last_word
);

    logic [LFSR_BITS-1:0]       r_seed_mod;
    logic [WORD_BITS-1:0]       r_base;
    logic [COUNT_BITS-1:0]      r_word_count;

    t_lfsr                      r_lfsr;
    logic [LFSR_BITS-1:0]       r_skip;
    logic [WORD_INDEX_BITS-1:0] r_idx;
    logic [WORD_BITS-1:0]       r_total;

    logic [WORD_BITS-1:0]       r_data_word;
    logic                       r_mismatch;
    logic [WORD_BITS-1:0]       r_word_address;
    logic [WORD_BITS-1:0]       r_error_count;
    logic                       r_last_word;

    logic [WORD_BITS-1:0]       w_word;
    t_lfsr                      n_lfsr;
    logic                       w_mis;
    logic [WORD_BITS-1:0]       n_total;
    logic [WORD_BITS-1:0]       w_addr;
    logic [WORD_BITS-1:0]       w_count_m1;
    logic [WORD_INDEX_BITS-1:0] w_last_idx;
    logic                       w_last;
    logic [WORD_INDEX_BITS-1:0] n_idx;

    // Configuration registers; the seed is stored already reduced to one period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_mod   <= '0;
            r_base       <= '0;
            r_word_count <= COUNT_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEED:  r_seed_mod   <= seed_reduce(i_cfg_data);
                CFG_BASE:  r_base       <= i_cfg_data;
                CFG_COUNT: r_word_count <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pattern word and word bookkeeping
    always_comb begin
        w_word     = pattern_word(r_lfsr);
        n_lfsr     = pattern_advance(r_lfsr);
        w_mis      = i_cmd.is_check && (i_read_data != w_word);
        n_total    = (w_mis && (r_total != '1)) ? r_total + 1'b1 : r_total;
        w_addr     = r_base + (WORD_BITS'(r_idx) << 2);
        w_count_m1 = {1'b0, r_word_count} - WORD_BITS'(1);
        w_last_idx = w_count_m1[WORD_INDEX_BITS-1:0];
        w_last     = (r_idx == w_last_idx);
        n_idx      = w_last ? '0 : r_idx + 1'b1;
    end

    // Generator state, skip counter, index and error total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= LFSR_SEED;
            r_skip  <= '0;
            r_idx   <= '0;
            r_total <= '0;
        end else if (i_cmd.restart) begin
            r_lfsr  <= LFSR_SEED;
            r_skip  <= r_seed_mod;
            r_idx   <= '0;
            r_total <= '0;
        end else if (i_cmd.skip_step) begin
            r_lfsr  <= n_lfsr;
            r_skip  <= r_skip - 1'b1;
        end else if (i_cmd.word_op) begin
            r_lfsr  <= n_lfsr;
            r_idx   <= n_idx;
            r_total <= n_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.word_op) begin
            r_data_word    <= w_word;
            r_mismatch     <= w_mis;
            r_word_address <= w_addr;
            r_error_count  <= n_total;
            r_last_word    <= w_last;
        end else if (i_cmd.res_restart) begin
            r_data_word    <= '0;
            r_mismatch     <= 1'b0;
            r_word_address <= r_base;
            r_error_count  <= '0;
            r_last_word    <= 1'b0;
        end else if (i_cmd.res_zero) begin
            r_data_word    <= '0;
            r_mismatch     <= 1'b0;
            r_word_address <= '0;
            r_error_count  <= '0;
            r_last_word    <= 1'b0;
        end
    end

    assign o_status.skip_done = (r_skip == '0);
    assign o_data_word        = r_data_word;
    assign o_mismatch         = r_mismatch;
    assign o_word_address     = r_word_address;
    assign o_error_count      = r_error_count;
    assign o_last_word        = r_last_word;

    `PMTC_ASSERT_NEXT(a_total_no_drop, i_clk, i_rst_n, !i_cmd.restart, r_total >= $past(r_total), "error total dropped without restart")
    `PMTC_ASSERT_IMPL(a_skip_nonzero, i_clk, i_rst_n, i_cmd.skip_step, r_skip != '0, "skip step with empty skip counter")

endmodule

// ===== src/pmtc_controller.sv =====
`include "assert_macros.svh"

module pmtc_controller import pmtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_kind      i_kind,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_out_free;
    logic    w_accept;
    logic    w_load;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        w_out_free = !r_out_valid || i_out_ready;
        o_in_ready = (r_state == ST_IDLE) && w_out_free;
        w_accept   = i_in_valid && o_in_ready;
        o_cmd      = '0;
        w_load     = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_kind) inside
                        KIND_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_state       = ST_SKIP;
                        end
                        KIND_WRITE, KIND_CHECK: begin
                            o_cmd.word_op  = 1'b1;
                            o_cmd.is_check = (i_kind == KIND_CHECK);
                            w_load         = 1'b1;
                        end
                        default: begin
                            o_cmd.res_zero = 1'b1;
                            w_load         = 1'b1;
                        end
                    endcase
                end
            end
            ST_SKIP: begin
                // advance one word per cycle, then post the restart result
                if (!i_status.skip_done) begin
                    o_cmd.skip_step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.res_restart = 1'b1;
                    w_load            = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // hold the result until the transfer completes
        n_out_valid = w_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

    `PMTC_ASSERT_NEXT(a_restart_skips, i_clk, i_rst_n, w_accept && (i_kind == KIND_RESTART), r_state == ST_SKIP, "restart did not enter skip")
    `PMTC_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_load, !r_out_valid || i_out_ready, "result loaded over a pending transfer")

endmodule

// ===== tb/pattern_result_checker.sv =====
`timescale 1ns / 100ps

module pattern_result_checker import pmtc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    pmtc_in_if                        i_item,
    pmtc_out_if                       i_result,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam logic [LFSR_BITS-1:0] PRBS_START = 15'h0001;
    localparam logic [LFSR_BITS-1:0] PRBS_TAPS  = 15'h6000;
    localparam int unsigned          PRBS_CYCLE = 32767;
    localparam int                   PRINT_CAP  = 30;

    typedef struct packed {
        logic [WORD_BITS-1:0] data_word;
        logic                 mismatch;
        logic [WORD_BITS-1:0] word_address;
        logic [WORD_BITS-1:0] error_count;
        logic                 last_word;
    } t_result;

    // Register copies
    logic [CFG_DATA_BITS-1:0]   seed_reg;
    logic [CFG_DATA_BITS-1:0]   base_reg;
    logic [COUNT_BITS-1:0]      count_reg;

    // Pattern engine state
    logic [LFSR_BITS-1:0]       gen_state;
    logic [WORD_INDEX_BITS-1:0] word_idx;
    logic [WORD_BITS-1:0]       err_total;

    t_result pending_results[$];

    // Step the generator through one word, first bit out lands in bit 0
    function automatic logic [WORD_BITS-1:0] next_pattern_word();
        logic [WORD_BITS-1:0] w;
        logic                 bit_out;
        w = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            bit_out = gen_state[0];
            gen_state = gen_state >> 1;
            if (bit_out) gen_state = gen_state ^ PRBS_TAPS;
            w[b] = bit_out;
        end
        return w;
    endfunction

    // Work out the result of one item and advance the engine state
    function automatic t_result predict_pattern_result(input t_kind k,
                                                       input logic [WORD_BITS-1:0] rd);
        t_result                    r;
        logic [WORD_INDEX_BITS-1:0] last_idx;
        int unsigned                skip;
        r = '0;
        last_idx = WORD_INDEX_BITS'(count_reg - 1'b1);
        case (k)
            KIND_RESTART: begin
                gen_state = PRBS_START;
                word_idx = '0;
                err_total = '0;
                skip = seed_reg % PRBS_CYCLE;
                repeat (skip) void'(next_pattern_word());
                r.word_address = base_reg;
            end
            KIND_WRITE, KIND_CHECK: begin
                r.data_word = next_pattern_word();
                r.word_address = base_reg + (WORD_BITS'(word_idx) << 2);
                if (k == KIND_CHECK && rd != r.data_word) begin
                    r.mismatch = 1'b1;
                    if (err_total != '1) err_total = err_total + 1'b1;
                end
                r.error_count = err_total;
                // Wrap the index after the region's final word
                if (word_idx == last_idx) begin
                    r.last_word = 1'b1;
                    word_idx = '0;
                end else begin
                    word_idx = word_idx + 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_BITS-1:0] want_v,
                                 input logic [WORD_BITS-1:0] got_v);
        if (want_v !== got_v) begin
            if (o_fail_count < PRINT_CAP)
                $error("%s: expected %h, actual %h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            seed_reg   = '0;
            base_reg   = '0;
            count_reg  = COUNT_BITS'(1);
            gen_state  = PRBS_START;
            word_idx   = '0;
            err_total  = '0;
            pending_results.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_SEED:  seed_reg = i_cfg_data;
                    CFG_BASE:  base_reg = i_cfg_data;
                    CFG_COUNT: count_reg = i_cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            // Compare the result transfer against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                seen.data_word    = i_result.data_word;
                seen.mismatch     = i_result.mismatch;
                seen.word_address = i_result.word_address;
                seen.error_count  = i_result.error_count;
                seen.last_word    = i_result.last_word;
                if (pending_results.size() == 0) begin
                    if (o_fail_count < PRINT_CAP)
                        $error("result with no item outstanding: data_word %h address %h",
                               seen.data_word, seen.word_address);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("data_word", want.data_word, seen.data_word);
                    compare_field("mismatch", WORD_BITS'(want.mismatch),
                                  WORD_BITS'(seen.mismatch));
                    compare_field("word_address", want.word_address, seen.word_address);
                    compare_field("error_count", want.error_count, seen.error_count);
                    compare_field("last_word", WORD_BITS'(want.last_word),
                                  WORD_BITS'(seen.last_word));
                end
            end
            // Predict the item transfer
            if (i_item.valid && i_item.ready)
                pending_results.push_back(predict_pattern_result(t_kind'(i_item.kind),
                                                                 i_item.read_data));
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== tb/prbs_memory_test_checker_unit_test.sv =====
`timescale 1ns / 100ps

module prbs_memory_test_checker_unit_test;
    import pmtc_pkg::*;

    localparam int STALL_LIMIT  = 200000;
    localparam int IDLE_ITEMS   = 1550;
    localparam int TOTAL_ITEMS  = 1650;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    pmtc_in_if  in_ch ();
    pmtc_out_if out_ch ();

    int fail_count;
    int pending_count;

    bit idle_on;
    int stall_left;
    int costly_left;
    int sent_total;
    int seen_total;
    int item_total;
    int kind_tally[4];
    int flagged_words;
    int region_ends;

    t_kind               kinds_in_flight[$];
    logic [WORD_BITS-1:0] mem_image[logic [WORD_BITS-1:0]];

    prbs_memory_test_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_ch),
        .o_result    (out_ch)
    );

    pattern_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop ready in short random bursts while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Record written words so later checks can read them back
    always @(posedge i_clk) begin
        t_kind k;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_total++;
            k = kinds_in_flight.pop_front();
            if (k == KIND_WRITE) mem_image[out_ch.word_address] = out_ch.data_word;
            flagged_words += out_ch.mismatch;
            region_ends += out_ch.last_word;
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("prbs_memory_test_checker_unit_test: done, errors");
        $finish;
    end

    // Offer one item, with an optional gap ahead of it, and hold it until transfer
    task automatic send_item(input t_kind k, input logic [WORD_BITS-1:0] rd);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.read_data <= rd;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        kinds_in_flight.push_back(k);
        sent_total++;
        kind_tally[k]++;
        if (k != KIND_NONE) item_total++;
    endtask

    // Stop offering items and wait until every result has come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sent_total != seen_total) @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [CFG_DATA_BITS-1:0] seed,
                                  input logic [CFG_DATA_BITS-1:0] base,
                                  input logic [COUNT_BITS-1:0] count);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SEED;
        i_cfg_data  <= seed;
        @(negedge i_clk);
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(negedge i_clk);
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= CFG_DATA_BITS'(count);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Read back word i of the region, sometimes with damage
    task automatic check_word(input logic [WORD_BITS-1:0] base, input int i);
        logic [WORD_BITS-1:0] addr;
        logic [WORD_BITS-1:0] rd;
        addr = base + (WORD_BITS'(i) << 2);
        rd = mem_image.exists(addr) ? mem_image[addr] : $urandom;
        case ($urandom_range(0, 15))
            0, 1:    rd = rd ^ (WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1));
            2:       rd = $urandom;
            default: ;
        endcase
        send_item(KIND_CHECK, rd);
    endtask

    // Restart, write the region, restart, read it back, then some stray items
    task automatic memory_pass(input logic [WORD_BITS-1:0] base, input int n,
                               input bit costly);
        t_kind k;
        send_item(KIND_RESTART, $urandom);
        for (int i = 0; i < n; i++) send_item(KIND_WRITE, $urandom);
        drain();
        send_item(KIND_RESTART, $urandom);
        for (int i = 0; i < n; i++) check_word(base, i);
        repeat ($urandom_range(0, 6)) begin
            k = costly ? t_kind'($urandom_range(1, 3)) : t_kind'($urandom_range(0, 3));
            send_item(k, $urandom);
        end
    endtask

    task automatic random_phase(input bit allow_idle);
        logic [CFG_DATA_BITS-1:0] seed;
        logic [CFG_DATA_BITS-1:0] base;
        logic [COUNT_BITS-1:0]    count;
        int                       sel;
        int                       n;
        bit                       costly;
        costly = 1'b0;
        sel = $urandom_range(0, 11);
        if (sel == 0) begin
            seed = '1;
        end else if (sel == 1) begin
            seed = 32'd32767;
        end else if (sel == 2 && costly_left > 0) begin
            // Long skips are slow, keep them few
            seed = $urandom_range(0, 1) ? 32'd32766 : 32'($urandom);
            costly = 1'b1;
            costly_left--;
        end else begin
            seed = $urandom_range(0, 40);
        end
        case ($urandom_range(0, 5))
            0:       base = '0;
            1:       base = '1;
            2:       base = 32'hFFFF_FFFC;
            default: base = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       count = '0;
            1:       count = '1;
            2:       count = 31'h4000_0000;
            default: count = $urandom_range(1, 24);
        endcase
        n = (count >= 1 && count <= 24) ? int'(count) : $urandom_range(4, 20);
        drain();
        idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        load_registers(seed, base, count);
        repeat (costly ? 1 : $urandom_range(2, 4)) memory_pass(base, n, costly);
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_RESTART;
        in_ch.read_data = '0;
        out_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_SEED;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        idle_on         = 1'b1;
        costly_left     = 3;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: one-word region, no skip, base zero
        send_item(KIND_WRITE, '0);
        send_item(KIND_WRITE, '1);
        send_item(KIND_NONE, '1);
        send_item(KIND_CHECK, '0);
        send_item(KIND_CHECK, '1);
        send_item(KIND_RESTART, '0);
        drain();

        // Longest skip, address wrap past the top of memory
        load_registers(32'd32766, 32'hFFFF_FFFC, 31'd3);
        send_item(KIND_RESTART, '1);
        repeat (3) send_item(KIND_WRITE, $urandom);
        drain();
        send_item(KIND_RESTART, $urandom);
        for (int i = 0; i < 3; i++)
            send_item(KIND_CHECK, mem_image[32'hFFFF_FFFC + (WORD_BITS'(i) << 2)]);
        send_item(KIND_CHECK, '0);
        drain();

        // All-ones seed and base, count of zero marks the highest index
        load_registers('1, '1, '0);
        send_item(KIND_RESTART, $urandom);
        send_item(KIND_WRITE, $urandom);
        send_item(KIND_CHECK, $urandom);
        send_item(KIND_NONE, '0);

        while (item_total < IDLE_ITEMS) random_phase(1'b1);
        idle_on = 1'b0;
        while (item_total < TOTAL_ITEMS) random_phase(1'b0);

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d items: %0d restarts, %0d writes, %0d checks, %0d ignored",
                 sent_total, kind_tally[KIND_RESTART], kind_tally[KIND_WRITE],
                 kind_tally[KIND_CHECK], kind_tally[KIND_NONE]);
        $display("results flagged %0d bad words and %0d region ends",
                 flagged_words, region_ends);
        if (pending_count != 0)
            $error("%0d predicted results never arrived", pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("prbs_memory_test_checker_unit_test: done, clean");
        end else begin
            $display("prbs_memory_test_checker_unit_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pmtc_pkg.sv
src/pmtc_in_if.sv
src/pmtc_out_if.sv
src/pmtc_datapath.sv
src/pmtc_controller.sv
src/prbs_memory_test_checker_unit.sv
tb/pattern_result_checker.sv
tb/prbs_memory_test_checker_unit_test.sv
